>>> rtl/core/smix_pkg.sv
// Shared types, constants and helper functions of the sample channel mixer.
package smix_pkg;

  localparam int unsigned CHANNELS_DEF         = 8;
  localparam int unsigned SAMPLE_MEM_DEPTH_DEF = 65536;

  // Item kinds carried on the input tuser.
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_SETUP = 2'd2
  } mode_e;

  localparam logic [1:0] PLAY_OFF  = 2'd0;
  localparam logic [1:0] PLAY_ONCE = 2'd1;
  localparam logic [1:0] PLAY_LOOP = 2'd2;

  localparam logic [15:0] LOOP_MIN = 16'd2;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CHAN_W   = 3;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PLAY_W   = 2;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned VOL_W    = 7;
  localparam int unsigned STEP_W   = 20;
  localparam int unsigned PHASE_W  = 16;
  localparam int unsigned CARRY_W  = 5;
  localparam int unsigned SAMPLE_W = 16;

  // Input tdata layout, lowest field first.
  localparam int unsigned CHAN_LSB   = 0;
  localparam int unsigned ADDR_LSB   = CHAN_LSB + CHAN_W;
  localparam int unsigned BYTE_LSB   = ADDR_LSB + ADDR_W;
  localparam int unsigned PLAY_LSB   = BYTE_LSB + BYTE_W;
  localparam int unsigned LEN_LSB    = PLAY_LSB + PLAY_W;
  localparam int unsigned LSTART_LSB = LEN_LSB + LEN_W;
  localparam int unsigned LLEN_LSB   = LSTART_LSB + LEN_W;
  localparam int unsigned VOL_LSB    = LLEN_LSB + LEN_W;
  localparam int unsigned STEP_LSB   = VOL_LSB + VOL_W;
  localparam int unsigned IN_FIELDS_W = STEP_LSB + STEP_W;
  localparam int unsigned IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;

  // Sample address reduction works on base + position, which needs 17 bits.
  localparam int unsigned RED_W   = ADDR_W + 1;
  localparam longint unsigned RED_MAX = (64'd1 << RED_W) - 64'd1;

  // Number of compare-and-subtract steps that bring any RED_W-bit value
  // below the memory depth.
  function automatic int unsigned red_steps(input longint unsigned depth);
    int unsigned n;
    n = 0;
    for (int k = 0; k < RED_W; k++) begin
      if ((depth << k) <= RED_MAX) begin
        n = k + 1;
      end
    end
    return n;
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_LOAD,
    ST_RUN,
    ST_MAC,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic setup_en;
    logic wr_start;
    logic wr_commit;
    logic cnt_clear;
    logic cnt_inc;
    logic chan_load;
    logic adv_en;
    logic rd_en;
    logic mac_en;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic red_done;
    logic car_zero;
    logic chan_active;
    logic last_chan;
    logic out_busy;
  } dp_stat_t;

endpackage

>>> rtl/core/smix_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module smix_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/smix_ctrl.sv
// Controller state machine that sequences writes, set-ups and mix ticks.
module smix_ctrl import smix_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic [1:0]  s_tuser_i,
  output logic        s_tready_o,
  input  dp_stat_t    stat_i,
  output dp_cmd_t     cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          case (mode_e'(s_tuser_i))
            MODE_TICK: begin
              cmd_o.cnt_clear = 1'b1;
              state_d         = ST_LOAD;
            end
            MODE_WRITE: begin
              cmd_o.wr_start = 1'b1;
              state_d        = ST_WRITE;
            end
            MODE_SETUP: begin
              cmd_o.setup_en = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_WRITE: begin
        if (stat_i.red_done) begin
          cmd_o.wr_commit = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_LOAD: begin
        if (stat_i.chan_active) begin
          cmd_o.chan_load = 1'b1;
          state_d         = ST_RUN;
        end else if (stat_i.last_chan) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      ST_RUN: begin
        cmd_o.adv_en = 1'b1;
        // The read goes out once the address is reduced and all position advances are done.
        if (stat_i.red_done && stat_i.car_zero) begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_MAC;
        end
      end
      ST_MAC: begin
        cmd_o.mac_en = 1'b1;
        if (stat_i.last_chan) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = ST_LOAD;
        end
      end
      ST_OUT: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/smix_dp.sv
// Datapath: channel registers, address reducer, sample memory, accumulator.
module smix_dp import smix_pkg::*; #(
  parameter int unsigned CHANNELS         = CHANNELS_DEF,
  parameter int unsigned SAMPLE_MEM_DEPTH = SAMPLE_MEM_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_cmd_t                cmd_i,
  output dp_stat_t               stat_o,
  input  logic [IN_TDATA_W-1:0]  in_tdata_i,
  input  logic                   m_tready_i,
  output logic                   m_tvalid_o,
  output logic [OUT_TDATA_W-1:0] m_tdata_o
);

  localparam int unsigned CW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned AW        = $clog2(SAMPLE_MEM_DEPTH);
  localparam int unsigned RED_STEPS = red_steps(SAMPLE_MEM_DEPTH);
  localparam int unsigned RCW       = (RED_STEPS > 0) ? $clog2(RED_STEPS + 1) : 1;

  // Input fields.
  logic [CHAN_W-1:0]  in_chan;
  logic [ADDR_W-1:0]  in_addr;
  logic [BYTE_W-1:0]  in_byte;
  logic [PLAY_W-1:0]  in_play;
  logic [LEN_W-1:0]   in_len;
  logic [LEN_W-1:0]   in_lstart;
  logic [LEN_W-1:0]   in_llen;
  logic [VOL_W-1:0]   in_vol;
  logic [STEP_W-1:0]  in_step;

  assign in_chan   = in_tdata_i[CHAN_LSB   +: CHAN_W];
  assign in_addr   = in_tdata_i[ADDR_LSB   +: ADDR_W];
  assign in_byte   = in_tdata_i[BYTE_LSB   +: BYTE_W];
  assign in_play   = in_tdata_i[PLAY_LSB   +: PLAY_W];
  assign in_len    = in_tdata_i[LEN_LSB    +: LEN_W];
  assign in_lstart = in_tdata_i[LSTART_LSB +: LEN_W];
  assign in_llen   = in_tdata_i[LLEN_LSB   +: LEN_W];
  assign in_vol    = in_tdata_i[VOL_LSB    +: VOL_W];
  assign in_step   = in_tdata_i[STEP_LSB   +: STEP_W];

  // Channel registers.
  logic [PLAY_W-1:0]  st_q     [CHANNELS];
  logic [ADDR_W-1:0]  pos_q    [CHANNELS];
  logic [PHASE_W-1:0] phase_q  [CHANNELS];
  logic [ADDR_W-1:0]  base_q   [CHANNELS];
  logic [LEN_W-1:0]   len_q    [CHANNELS];
  logic [LEN_W-1:0]   lstart_q [CHANNELS];
  logic [LEN_W-1:0]   llen_q   [CHANNELS];
  logic [VOL_W-1:0]   vol_q    [CHANNELS];
  logic [STEP_W-1:0]  step_q   [CHANNELS];

  logic [CW-1:0]      cnt_q;
  logic [CARRY_W-1:0] car_q;
  logic [SAMPLE_W-1:0] sum_q;
  logic [RED_W-1:0]   red_val_q;
  logic [RCW-1:0]     red_cnt_q;
  logic [BYTE_W-1:0]  wbyte_q;
  logic               out_valid_q;
  logic [SAMPLE_W-1:0] out_data_q;

  logic               setup_hit;
  logic [CW-1:0]      setup_idx;
  logic [PLAY_W-1:0]  st_cur, st_nxt;
  logic [ADDR_W-1:0]  pos_cur, pos_inc, pos_nxt;
  logic [LEN_W-1:0]   len_cur, lstart_cur, llen_cur;
  logic [RED_W-1:0]   diff;
  logic [PHASE_W+CARRY_W-1:0] acc;
  logic               adv_fire;
  logic [RCW-1:0]     red_kc;
  logic [RED_W-1:0]   red_cmp;
  logic [AW-1:0]      mem_addr;
  logic [BYTE_W-1:0]  rdata;
  logic signed [SAMPLE_W-1:0] prod;

  assign setup_hit = cmd_i.setup_en && (32'(in_chan) < CHANNELS);
  assign setup_idx = CW'(in_chan);

  assign st_cur     = st_q[cnt_q];
  assign pos_cur    = pos_q[cnt_q];
  assign len_cur    = len_q[cnt_q];
  assign lstart_cur = lstart_q[cnt_q];
  assign llen_cur   = llen_q[cnt_q];

  // Phase plus step: the upper bits count the position advances of this tick.
  assign acc = (PHASE_W + CARRY_W)'(phase_q[cnt_q]) + (PHASE_W + CARRY_W)'(step_q[cnt_q]);

  assign adv_fire = cmd_i.adv_en && (car_q != '0);

  // One position advance; the loop test uses a signed distance from loop start.
  always_comb begin
    pos_inc = pos_cur + 16'd1;
    diff    = {1'b0, pos_inc} - {1'b0, lstart_cur};
    st_nxt  = st_cur;
    pos_nxt = pos_inc;
    if (st_cur == PLAY_ONCE) begin
      if (pos_inc >= len_cur) begin
        st_nxt = (llen_cur > LOOP_MIN) ? PLAY_LOOP : PLAY_OFF;
      end
    end else if ($signed(diff) >= $signed({1'b0, llen_cur})) begin
      pos_nxt = lstart_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        st_q[i]    <= PLAY_OFF;
        pos_q[i]   <= '0;
        phase_q[i] <= '0;
      end
    end else if (setup_hit) begin
      st_q[setup_idx]    <= in_play;
      pos_q[setup_idx]   <= '0;
      phase_q[setup_idx] <= '0;
    end else begin
      if (cmd_i.chan_load) begin
        phase_q[cnt_q] <= acc[PHASE_W-1:0];
      end
      if (adv_fire) begin
        st_q[cnt_q]  <= st_nxt;
        pos_q[cnt_q] <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (setup_hit) begin
      base_q[setup_idx]   <= in_addr;
      len_q[setup_idx]    <= in_len;
      lstart_q[setup_idx] <= in_lstart;
      llen_q[setup_idx]   <= in_llen;
      vol_q[setup_idx]    <= in_vol;
      step_q[setup_idx]   <= in_step;
    end
  end

  // Address reducer: restoring reduction modulo the memory depth, one step a cycle.
  assign red_kc  = red_cnt_q - RCW'(1);
  assign red_cmp = RED_W'(SAMPLE_MEM_DEPTH) << red_kc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_cnt_q <= '0;
    end else if (cmd_i.wr_start || cmd_i.chan_load) begin
      red_cnt_q <= RCW'(RED_STEPS);
    end else if (red_cnt_q != '0) begin
      red_cnt_q <= red_kc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_start) begin
      red_val_q <= RED_W'(in_addr);
      wbyte_q   <= in_byte;
    end else if (cmd_i.chan_load) begin
      red_val_q <= {1'b0, base_q[cnt_q]} + {1'b0, pos_cur};
    end else if ((red_cnt_q != '0) && (red_val_q >= red_cmp)) begin
      red_val_q <= red_val_q - red_cmp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      car_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_clear) begin
        cnt_q <= '0;
        sum_q <= '0;
      end else begin
        if (cmd_i.cnt_inc) begin
          cnt_q <= cnt_q + CW'(1);
        end
        if (cmd_i.mac_en) begin
          sum_q <= sum_q + prod;
        end
      end
      if (cmd_i.chan_load) begin
        car_q <= acc[PHASE_W +: CARRY_W];
      end else if (adv_fire) begin
        car_q <= car_q - CARRY_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= sum_q;
    end
  end

  assign mem_addr = AW'(red_val_q);

  smix_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SAMPLE_MEM_DEPTH)
  ) u_smix_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_commit),
    .waddr_i (mem_addr),
    .wdata_i (wbyte_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (mem_addr),
    .rdata_o (rdata)
  );

  // Sign-extended sample times zero-extended volume, both at the sum width.
  assign prod = $signed({{(SAMPLE_W-BYTE_W){rdata[BYTE_W-1]}}, rdata})
              * $signed({{(SAMPLE_W-VOL_W){1'b0}}, vol_q[cnt_q]});

  assign stat_o.red_done    = (red_cnt_q == '0);
  assign stat_o.car_zero    = (car_q == '0);
  assign stat_o.chan_active = (st_cur != PLAY_OFF);
  assign stat_o.last_chan   = (cnt_q == CW'(CHANNELS - 1));
  assign stat_o.out_busy    = out_valid_q && !m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = OUT_TDATA_W'(out_data_q);

endmodule

>>> rtl/core/sample_channel_mixer.sv
// A set-up completes in the cycle it is accepted. A sample write reduces its address in R
// steps (one step at the default depth), then writes its byte. A mix tick skips each silent
// channel; an active channel reduces its read address while it takes its carries (0 to 16),
// the position advances of that channel, then reads and accumulates; the tick ends by loading
// the result, held off while an earlier result is still stalled. Items go one at a time.
// Reset is asynchronous, active low: all channels off, position and phase zero.
module sample_channel_mixer import smix_pkg::*; #(
  parameter int unsigned CHANNELS         = CHANNELS_DEF,
  parameter int unsigned SAMPLE_MEM_DEPTH = SAMPLE_MEM_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // channel, address, sample_byte, play_state, length, loop_start,
  // loop_length, volume, step
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // mode
  input  logic [MODE_W-1:0]      s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // mixed_sample
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  smix_ctrl u_smix_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tuser_i  (s_axis_tuser_i),
    .s_tready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  smix_dp #(
    .CHANNELS         (CHANNELS),
    .SAMPLE_MEM_DEPTH (SAMPLE_MEM_DEPTH)
  ) u_smix_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_tdata_i (s_axis_tdata_i),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o)
  );

endmodule

>>> rtl/core/smix_chk.sv
// Port-level checker for the sample channel mixer and its bind.
module smix_chk import smix_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_i,
  input logic [MODE_W-1:0]      s_axis_tuser_i,
  input logic                   m_axis_tvalid_i,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_i
);

  logic s_xfer;
  assign s_xfer = s_axis_tvalid_i && s_axis_tready_i;

  // A stalled result keeps its transfer pending with the same data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i))
    else $error("result changed while stalled");

  // A new result appears only as a tick finishes, while input is held off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_i) |-> $past(!s_axis_tready_i))
    else $error("result raised outside tick completion");

  // Ticks and sample writes occupy the block after their transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && (s_axis_tuser_i == MODE_TICK || s_axis_tuser_i == MODE_WRITE)
    |=> !s_axis_tready_i)
    else $error("input accepted during tick or write");

  // A set-up completes in its own cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && (s_axis_tuser_i == MODE_SETUP) |=> s_axis_tready_i)
    else $error("set-up did not return to ready");

endmodule

bind sample_channel_mixer smix_chk u_smix_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);

>>> verif/sample_channel_mixer_tb.sv
// Self-checking testbench of the sample channel mixer: directed and random item streams.
`timescale 1ns / 100ps

module sample_channel_mixer_tb;
  import smix_pkg::*;

  localparam int unsigned NCH             = CHANNELS_DEF;
  localparam logic [1:0]  MODE_IGNORED    = 2'd3;
  localparam logic [1:0]  PLAY_ALT_LOOP   = 2'd3;
  localparam int unsigned ITEM_TARGET     = 1250;
  localparam int unsigned IDLE_PCT        = 27;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned DRAIN_CYCLES    = 200;
  localparam int unsigned HOLD_OFF_CYCLES = 600;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [CHAN_W-1:0] chan;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] sbyte;
    logic [PLAY_W-1:0] play;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  lstart;
    logic [LEN_W-1:0]  llen;
    logic [VOL_W-1:0]  vol;
    logic [STEP_W-1:0] step;
  } mix_item_t;

  typedef logic [ADDR_W-1:0] addr_q_t[$];

  // Shadow copy of the mixer: channel state, written sample bytes and the
  // mixed samples still owed by the block.
  class mixer_shadow;
    bit [BYTE_W-1:0]     sample_mem[int unsigned];
    logic [PLAY_W-1:0]   play[NCH];
    logic [ADDR_W-1:0]   base[NCH];
    logic [LEN_W-1:0]    pos[NCH];
    logic [PHASE_W-1:0]  phase[NCH];
    logic [LEN_W-1:0]    len[NCH];
    logic [LEN_W-1:0]    lstart[NCH];
    logic [LEN_W-1:0]    llen[NCH];
    logic [VOL_W-1:0]    vol[NCH];
    logic [STEP_W-1:0]   step[NCH];
    logic [SAMPLE_W-1:0] expected_mix[$];
    int unsigned         failures;

    function new();
      for (int c = 0; c < NCH; c++) begin
        play[c]   = PLAY_OFF;
        base[c]   = '0;
        pos[c]    = '0;
        phase[c]  = '0;
        len[c]    = '0;
        lstart[c] = '0;
        llen[c]   = '0;
        vol[c]    = '0;
        step[c]   = '0;
      end
      failures = 0;
    endfunction

    function logic [ADDR_W-1:0] read_addr(int c);
      return base[c] + pos[c];
    endfunction

    // One position advance. A channel that is off still follows the loop rule.
    function void move_on(int c);
      int diff;
      pos[c] = pos[c] + 1'b1;
      if (play[c] == PLAY_ONCE) begin
        if (pos[c] >= len[c]) begin
          play[c] = (llen[c] > LOOP_MIN) ? PLAY_LOOP : PLAY_OFF;
        end
      end else begin
        diff = int'(pos[c]) - int'(lstart[c]);
        if (diff >= int'(llen[c])) begin
          pos[c] = lstart[c];
        end
      end
    endfunction

    function logic [SAMPLE_W-1:0] mix_tick();
      logic [SAMPLE_W-1:0] sum;
      logic [STEP_W:0]     acc;
      int                  product;
      sum = '0;
      for (int c = 0; c < NCH; c++) begin
        if (play[c] != PLAY_OFF) begin
          product = int'($signed(sample_mem[read_addr(c)])) * int'(vol[c]);
          sum = sum + product[SAMPLE_W-1:0];
          acc = phase[c] + step[c];
          phase[c] = acc[PHASE_W-1:0];
          repeat (acc[STEP_W:PHASE_W]) move_on(c);
        end
      end
      return sum;
    endfunction

    // Sample addresses the next tick would read that hold no written byte yet.
    function addr_q_t missing_reads();
      addr_q_t gaps;
      for (int c = 0; c < NCH; c++) begin
        if (play[c] != PLAY_OFF && !sample_mem.exists(read_addr(c))) begin
          gaps.push_back(read_addr(c));
        end
      end
      return gaps;
    endfunction

    function void note_item(mix_item_t it);
      int c;
      c = it.chan;
      case (it.mode)
        MODE_WRITE: sample_mem[it.addr] = it.sbyte;
        MODE_SETUP: begin
          play[c]   = it.play;
          base[c]   = it.addr;
          len[c]    = it.len;
          lstart[c] = it.lstart;
          llen[c]   = it.llen;
          vol[c]    = it.vol;
          step[c]   = it.step;
          pos[c]    = '0;
          phase[c]  = '0;
        end
        MODE_TICK: expected_mix.push_back(mix_tick());
        default: ;
      endcase
    endfunction

    function void check_sample(logic [SAMPLE_W-1:0] got);
      logic [SAMPLE_W-1:0] want;
      if (expected_mix.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("mixed_sample %0d arrived with nothing expected", $signed(got));
        end
      end else begin
        want = expected_mix.pop_front();
        if (got !== want) begin
          failures++;
          if (failures <= MAX_REPORTS) begin
            $display("mixed_sample mismatch: expected %0d, got %0d",
                     $signed(want), $signed(got));
          end
        end
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [MODE_W-1:0]      s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  mixer_shadow sb;
  // Stepped when an item is offered, so that every byte a tick will read
  // can be written ahead of it.
  mixer_shadow lookahead;
  int unsigned items_sent = 0;
  int unsigned samples_seen = 0;

  sample_channel_mixer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [IN_TDATA_W-1:0] pack_fields(mix_item_t it);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[CHAN_LSB +: CHAN_W]   = it.chan;
    d[ADDR_LSB +: ADDR_W]   = it.addr;
    d[BYTE_LSB +: BYTE_W]   = it.sbyte;
    d[PLAY_LSB +: PLAY_W]   = it.play;
    d[LEN_LSB +: LEN_W]     = it.len;
    d[LSTART_LSB +: LEN_W]  = it.lstart;
    d[LLEN_LSB +: LEN_W]    = it.llen;
    d[VOL_LSB +: VOL_W]     = it.vol;
    d[STEP_LSB +: STEP_W]   = it.step;
    return d;
  endfunction

  function automatic mix_item_t random_item();
    mix_item_t it;
    it.mode   = MODE_W'($urandom_range(3));
    it.chan   = CHAN_W'($urandom);
    it.addr   = ADDR_W'($urandom);
    it.sbyte  = BYTE_W'($urandom);
    it.play   = PLAY_W'($urandom);
    it.len    = LEN_W'($urandom);
    it.lstart = LEN_W'($urandom);
    it.llen   = LEN_W'($urandom);
    it.vol    = VOL_W'($urandom);
    it.step   = STEP_W'($urandom);
    return it;
  endfunction

  function automatic mix_item_t write_item(logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] b);
    mix_item_t it;
    it = random_item();
    it.mode  = MODE_WRITE;
    it.addr  = addr;
    it.sbyte = b;
    return it;
  endfunction

  function automatic mix_item_t tick_item();
    mix_item_t it;
    it = random_item();
    it.mode = MODE_TICK;
    return it;
  endfunction

  function automatic mix_item_t setup_item(int chan, logic [PLAY_W-1:0] play,
                                           logic [ADDR_W-1:0] base, logic [LEN_W-1:0] len,
                                           logic [LEN_W-1:0] lstart, logic [LEN_W-1:0] llen,
                                           logic [VOL_W-1:0] vol, logic [STEP_W-1:0] step);
    mix_item_t it;
    it = random_item();
    it.mode   = MODE_SETUP;
    it.chan   = CHAN_W'(chan);
    it.play   = play;
    it.addr   = base;
    it.len    = len;
    it.lstart = lstart;
    it.llen   = llen;
    it.vol    = vol;
    it.step   = step;
    return it;
  endfunction

  // Mostly short samples and loops, so that playback reaches its ends and
  // wraps often; now and then full-range values.
  function automatic mix_item_t shaped_setup(mix_item_t it);
    int unsigned r;
    it.mode = MODE_SETUP;
    r = $urandom_range(9);
    if (r == 0) it.play = PLAY_OFF;
    else if (r <= 4) it.play = PLAY_ONCE;
    else if (r <= 8) it.play = PLAY_LOOP;
    else it.play = PLAY_ALT_LOOP;
    if ($urandom_range(9) < 7) it.len = LEN_W'($urandom_range(40));
    if ($urandom_range(9) < 7) it.lstart = LEN_W'($urandom_range(40));
    r = $urandom_range(9);
    if (r < 6) it.llen = LEN_W'($urandom_range(8));
    else if (r < 9) it.llen = LEN_W'($urandom_range(64));
    r = $urandom_range(9);
    if (r < 2) it.vol = 7'd64;
    else if (r < 9) it.vol = VOL_W'($urandom_range(64));
    r = $urandom_range(9);
    if (r < 4) it.step = STEP_W'($urandom_range(32'h2_0000));
    else if (r < 7) it.step = STEP_W'($urandom_range(15)) << PHASE_W;
    return it;
  endfunction

  task automatic push_item(input mix_item_t it);
    @(negedge clk_i);
    while (!(items_sent >= 500 && items_sent < 700) && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_fields(it);
    s_axis_tuser  <= it.mode;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(it);
    if (it.mode != MODE_IGNORED) items_sent++;
  endtask

  // A tick is preceded by writes of any byte it would read that is still unwritten.
  task automatic offer_item(input mix_item_t it);
    addr_q_t   gaps;
    mix_item_t fill;
    if (it.mode == MODE_TICK) begin
      gaps = lookahead.missing_reads();
      foreach (gaps[i]) begin
        if (!lookahead.sample_mem.exists(gaps[i])) begin
          fill = write_item(gaps[i], BYTE_W'($urandom));
          lookahead.note_item(fill);
          push_item(fill);
        end
      end
    end
    lookahead.note_item(it);
    lookahead.expected_mix.delete();
    push_item(it);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_sample(m_axis_tdata[SAMPLE_W-1:0]);
      samples_seen++;
    end
  end

  // Result side: random stalls, one calm stretch, and one long hold-off that
  // backs the block up into its input.
  initial begin
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && samples_seen >= 150) begin
        held = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (samples_seen >= 300 && samples_seen < 450) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    #16_000_000;
    $display("[sample_channel_mixer] ERROR");
    $finish;
  end

  initial begin
    mix_item_t   it;
    int unsigned r;
    sb = new();
    lookahead = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Extreme bytes at both ends of memory, and a byte shared by all channels.
    offer_item(write_item(16'h0000, 8'h80));
    offer_item(write_item(16'hFFFF, 8'h7F));
    offer_item(write_item(16'h0100, 8'h80));
    it = random_item();
    it.mode = MODE_IGNORED;
    offer_item(it);
    // No channel active: silence.
    offer_item(tick_item());
    // Every channel at full negative value and top volume: the sum wraps.
    for (int c = 0; c < NCH; c++) begin
      offer_item(setup_item(c, PLAY_ONCE, 16'h0100, 16'd100, '0, '0, 7'd127, '0));
    end
    offer_item(tick_item());
    // One-shot into looping with the base at the top of memory, so the read
    // address wraps around.
    offer_item(setup_item(0, PLAY_ONCE, 16'hFFFF, 16'd2, 16'd0, 16'd3, 7'd64, 20'h10000));
    // One-shot with loop length two stops at its end.
    offer_item(setup_item(1, PLAY_ONCE, 16'h0000, 16'd1, 16'd0, 16'd2, 7'd1, 20'hFFFFF));
    offer_item(setup_item(2, PLAY_ALT_LOOP, 16'h0200, 16'd0, 16'd5, 16'd0, 7'd127, 20'hFFFFF));
    // Loop end beyond the position range: the position wraps at 16 bits.
    offer_item(setup_item(3, PLAY_LOOP, 16'hFFF0, 16'hFFFF, 16'hFFF0, 16'hFFFF, 7'd127,
                          20'hFFFFF));
    offer_item(setup_item(4, PLAY_LOOP, 16'h0100, 16'd0, 16'd0, 16'd0, 7'd0, 20'h08000));
    repeat (4) offer_item(tick_item());

    while (items_sent < ITEM_TARGET) begin
      it = random_item();
      r = $urandom_range(99);
      if (r < 45) begin
        it.mode = MODE_TICK;
      end else if (r < 70) begin
        it.mode = MODE_WRITE;
        // Half the writes land where some channel plays from.
        if ($urandom_range(1) == 1) begin
          it.addr = lookahead.base[$urandom_range(NCH - 1)] + ADDR_W'($urandom_range(63));
        end
      end else if (r < 95) begin
        it = shaped_setup(it);
      end else begin
        it.mode = MODE_IGNORED;
      end
      offer_item(it);
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_mix.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.failures == 0 && sb.expected_mix.size() == 0) begin
      $display("[sample_channel_mixer] OK");
    end else begin
      $display("[sample_channel_mixer] ERROR");
    end
    $finish;
  end

endmodule
